// ===== src/sfd_pkg.sv =====
// Package for the sensor frame deframer: status codes, frame constants,
// the result record and the bytewise CRC-8 step.
// Depends on nothing; used by src/sensor_frame_deframer.sv.
package sfd_pkg;

  // Status codes reported with each completed frame.
  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_BAD_CMP = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

  // Frame layout and field constants.
  localparam logic [7:0]  START_MARK    = 8'hA5;
  localparam logic [7:0]  LIVE_CMD      = 8'h04;
  localparam logic [15:0] SFLOAT_NAN    = 16'h07FF;
  localparam int          LEN_W         = 10;
  localparam logic [9:0]  MIN_START_LEN = 10'd7;
  localparam int          DECL_W        = 17;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
  localparam logic [7:0]  MAX_SPO2      = 8'd100;
  localparam logic [7:0]  PULSE_LIMIT   = 8'd250;
  localparam logic [7:0]  PULSE_BAD     = 8'hFF;
  localparam logic [7:0]  MIN_READING_PAYLOAD = 8'd9;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic        has_reading;
    logic [7:0]  spo2_value;
    logic [7:0]  pulse_value;
    logic [15:0] spo2_code;
    logic [15:0] pulse_code;
    logic        reading_invalid;
  } result_t;

  // CRC-8, polynomial 0x07, MSB first, one byte per call.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== src/sensor_frame_deframer.sv =====
// Sensor frame deframer: reassembles chunked notification frames and
// reports status, command and decoded live-sample readings.
// Depends on src/sfd_pkg.sv.
// The result is registered as the last byte of the completing chunk is
// accepted: into the head, valid in the next cycle, or into the skid entry
// if the head is stalled. One byte per cycle while the skid entry is empty,
// as the CRC-8 update and frame counters are combinational. A two-entry
// output buffer keeps input flowing while a result waits. Synchronous reset
// clears all assembly state and empties the output buffer.
module sensor_frame_deframer #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        chunk_start,
  input  logic [9:0]  chunk_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  command,
  output logic [7:0]  payload_length,
  output logic        has_reading,
  output logic [7:0]  spo2_value,
  output logic [7:0]  pulse_value,
  output logic [15:0] spo2_code,
  output logic [15:0] pulse_code,
  output logic        reading_invalid
);

  localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
  localparam int SUM_W   = ((CNT_W > sfd_pkg::LEN_W) ? CNT_W : sfd_pkg::LEN_W) + 1;
  localparam int WIDE_W  = (CNT_W > 8) ? CNT_W : 8;

  // Assembly state.
  logic [CNT_W-1:0]         assembled_count, assembled_count_next;
  logic [CNT_W-1:0]         wanted_count, wanted_count_next;
  logic [sfd_pkg::LEN_W-1:0] chunk_remaining, chunk_remaining_next;
  logic                     chunk_dropped, chunk_dropped_next;
  logic [7:0]               length_low_byte, length_low_byte_next;
  logic [7:0]               command_byte, command_byte_next;
  logic [7:0]               complement_byte, complement_byte_next;
  logic [7:0]               running_crc, running_crc_next;
  logic [7:0]               latched_crc, latched_crc_next;
  logic [7:0]               received_crc, received_crc_next;
  logic [7:0]               saturation_byte, saturation_byte_next;
  logic [7:0]               pulse_byte, pulse_byte_next;

  // Output buffer: head register and one skid entry.
  logic              out_full;
  logic              skid_valid;
  sfd_pkg::result_t  out_reg;
  sfd_pkg::result_t  skid_reg;
  sfd_pkg::result_t  result_next;

  logic                     take;
  logic                     emit;
  logic                     byte_used;
  logic                     frame_abort;
  logic [CNT_W-1:0]         pos;
  logic [sfd_pkg::DECL_W-1:0] declared;
  logic [SUM_W-1:0]         fill_sum;
  logic [WIDE_W-1:0]        plen_wide;
  logic                     reading_ok;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;

  // Per-byte assembly, CRC and result evaluation.
  always_comb begin
    assembled_count_next = assembled_count;
    wanted_count_next    = wanted_count;
    chunk_remaining_next = chunk_remaining;
    chunk_dropped_next   = chunk_dropped;
    length_low_byte_next = length_low_byte;
    command_byte_next    = command_byte;
    complement_byte_next = complement_byte;
    running_crc_next     = running_crc;
    latched_crc_next     = latched_crc;
    received_crc_next    = received_crc;
    saturation_byte_next = saturation_byte;
    pulse_byte_next      = pulse_byte;
    frame_abort = 1'b0;
    emit        = 1'b0;
    pos         = assembled_count;
    declared    = '0;
    fill_sum    = '0;
    plen_wide   = '0;
    reading_ok  = 1'b0;
    result_next = '0;

    if (chunk_start) begin
      byte_used = (chunk_len != '0);
    end else begin
      byte_used = (chunk_remaining != '0);
    end

    if (byte_used) begin
      // A chunk start opens a new chunk and may restart or drop the frame.
      if (chunk_start) begin
        if (chunk_remaining != '0) begin
          assembled_count_next = '0;
          wanted_count_next    = '0;
          running_crc_next     = '0;
        end
        chunk_remaining_next = chunk_len;
        chunk_dropped_next   = 1'b0;
        fill_sum = SUM_W'(assembled_count_next) + SUM_W'(chunk_len);
        if (data_byte == sfd_pkg::START_MARK) begin
          assembled_count_next = '0;
          wanted_count_next    = '0;
          running_crc_next     = '0;
          if (chunk_len < sfd_pkg::MIN_START_LEN ||
              SUM_W'(chunk_len) > SUM_W'(BUFFER_BYTES)) begin
            chunk_dropped_next = 1'b1;
          end
        end else if (wanted_count_next == '0 || fill_sum > SUM_W'(BUFFER_BYTES)) begin
          assembled_count_next = '0;
          wanted_count_next    = '0;
          running_crc_next     = '0;
          chunk_dropped_next   = 1'b1;
        end
      end

      chunk_remaining_next = chunk_remaining_next - 1'b1;

      // Store the byte into the frame being assembled.
      if (!chunk_dropped_next) begin
        pos = assembled_count_next;
        if (pos == CNT_W'(1)) begin
          command_byte_next = data_byte;
        end else if (pos == CNT_W'(2)) begin
          complement_byte_next = data_byte;
        end else if (pos == CNT_W'(5)) begin
          length_low_byte_next = data_byte;
        end else if (pos == CNT_W'(13)) begin
          saturation_byte_next = data_byte;
        end else if (pos == CNT_W'(15)) begin
          pulse_byte_next = data_byte;
        end

        if (wanted_count_next == '0 ||
            SUM_W'(pos) + SUM_W'(1) < SUM_W'(wanted_count_next)) begin
          running_crc_next = sfd_pkg::crc8_step(running_crc_next, data_byte);
        end else if (SUM_W'(pos) + SUM_W'(1) == SUM_W'(wanted_count_next)) begin
          latched_crc_next  = running_crc_next;
          received_crc_next = data_byte;
        end

        assembled_count_next = pos + 1'b1;

        // The high length byte sets the frame size.
        if (pos == CNT_W'(6)) begin
          declared = {1'b0, data_byte, length_low_byte_next} + sfd_pkg::FRAME_OVERHEAD;
          if (declared > sfd_pkg::DECL_W'(BUFFER_BYTES)) begin
            assembled_count_next = '0;
            wanted_count_next    = '0;
            running_crc_next     = '0;
            chunk_dropped_next   = 1'b1;
            frame_abort          = 1'b1;
          end else begin
            wanted_count_next = declared[CNT_W-1:0];
          end
        end
      end

      emit = !frame_abort && chunk_remaining_next == '0 && !chunk_dropped_next &&
             wanted_count_next != '0 && assembled_count_next >= wanted_count_next;

      // Frame complete: check it and decode the reading.
      if (emit) begin
        if (complement_byte_next != ~command_byte_next) begin
          result_next.status = sfd_pkg::STATUS_BAD_CMP;
        end else if (latched_crc_next != received_crc_next) begin
          result_next.status = sfd_pkg::STATUS_BAD_CRC;
        end else begin
          result_next.status = sfd_pkg::STATUS_GOOD;
        end
        plen_wide = WIDE_W'(wanted_count_next) - WIDE_W'(8);
        result_next.command        = command_byte_next;
        result_next.payload_length = plen_wide[7:0];
        result_next.has_reading    = (result_next.status == sfd_pkg::STATUS_GOOD) &&
                                     (command_byte_next == sfd_pkg::LIVE_CMD) &&
                                     (plen_wide >= WIDE_W'(sfd_pkg::MIN_READING_PAYLOAD));
        result_next.spo2_code  = sfd_pkg::SFLOAT_NAN;
        result_next.pulse_code = sfd_pkg::SFLOAT_NAN;
        if (result_next.has_reading) begin
          result_next.spo2_value  = saturation_byte_next;
          result_next.pulse_value = pulse_byte_next;
          reading_ok = (saturation_byte_next != 8'd0) &&
                       (saturation_byte_next <= sfd_pkg::MAX_SPO2) &&
                       (pulse_byte_next != 8'd0) &&
                       (pulse_byte_next != sfd_pkg::PULSE_BAD) &&
                       (pulse_byte_next < sfd_pkg::PULSE_LIMIT);
          if (reading_ok) begin
            result_next.spo2_code  = {8'd0, saturation_byte_next};
            result_next.pulse_code = {8'd0, pulse_byte_next};
          end else begin
            result_next.reading_invalid = 1'b1;
          end
        end
        assembled_count_next = '0;
        wanted_count_next    = '0;
        running_crc_next     = '0;
      end
    end
  end

  // Assembly state registers, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      assembled_count <= '0;
      wanted_count    <= '0;
      chunk_remaining <= '0;
      chunk_dropped   <= 1'b0;
      length_low_byte <= '0;
      command_byte    <= '0;
      complement_byte <= '0;
      running_crc     <= '0;
      latched_crc     <= '0;
      received_crc    <= '0;
      saturation_byte <= '0;
      pulse_byte      <= '0;
    end else if (take) begin
      assembled_count <= assembled_count_next;
      wanted_count    <= wanted_count_next;
      chunk_remaining <= chunk_remaining_next;
      chunk_dropped   <= chunk_dropped_next;
      length_low_byte <= length_low_byte_next;
      command_byte    <= command_byte_next;
      complement_byte <= complement_byte_next;
      running_crc     <= running_crc_next;
      latched_crc     <= latched_crc_next;
      received_crc    <= received_crc_next;
      saturation_byte <= saturation_byte_next;
      pulse_byte      <= pulse_byte_next;
    end
  end

  // Output buffer: a result goes to the head, or to the skid entry if the
  // head is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_full || out_ready) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_full   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_reg  <= result_next;
        out_full <= take && emit;
      end
    end else if (take && emit) begin
      skid_reg   <= result_next;
      skid_valid <= 1'b1;
    end
  end

  assign out_valid       = out_full;
  assign status          = out_reg.status;
  assign command         = out_reg.command;
  assign payload_length  = out_reg.payload_length;
  assign has_reading     = out_reg.has_reading;
  assign spo2_value      = out_reg.spo2_value;
  assign pulse_value     = out_reg.pulse_value;
  assign spo2_code       = out_reg.spo2_code;
  assign pulse_code      = out_reg.pulse_code;
  assign reading_invalid = out_reg.reading_invalid;

endmodule

// ===== test/sfd_frame_checker.sv =====
// Frame checker for the sensor frame deframer: watches both channels, predicts
// each frame result from the accepted bytes and compares it field by field.
// Depends on src/sfd_pkg.sv for the status codes, frame constants and result type.
`timescale 1ns / 100ps

module sfd_frame_checker #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        chunk_start,
  input  logic [9:0]  chunk_len,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [7:0]  command,
  input  logic [7:0]  payload_length,
  input  logic        has_reading,
  input  logic [7:0]  spo2_value,
  input  logic [7:0]  pulse_value,
  input  logic [15:0] spo2_code,
  input  logic [15:0] pulse_code,
  input  logic        reading_invalid,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_PRINTED = 40;

  // Frame assembly state mirrored from the byte stream.
  logic [9:0] frame_fill;
  logic [8:0] frame_need;
  logic [9:0] chunk_left;
  logic       chunk_skip;
  logic [7:0] len_lo;
  logic [7:0] cmd_seen;
  logic [7:0] cmp_seen;
  logic [7:0] crc_run;
  logic [7:0] crc_hold;
  logic [7:0] crc_rx;
  logic [7:0] sat_seen;
  logic [7:0] pulse_seen;

  // Results predicted but not yet delivered, oldest first.
  sfd_pkg::result_t frames_due[$];

  // Serial form of the CRC-8 (polynomial 0x07), one data bit at a time.
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ d[k];
      r  = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count < MAX_PRINTED)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Abandon any frame in progress.
  task automatic drop_frame();
    frame_fill = '0;
    frame_need = '0;
    crc_run    = '0;
  endtask

  // Advance the prediction by one accepted input byte.
  task automatic feed_byte(input logic [7:0] b, input logic st, input logic [9:0] len);
    int               p;
    int               w;
    int               plen;
    sfd_pkg::result_t r;
    if (st) begin
      if (len == 0) return;
      // A new chunk cuts short a chunk that is still open.
      if (chunk_left != 0) drop_frame();
      chunk_left = len;
      chunk_skip = 1'b0;
      if (b == sfd_pkg::START_MARK) begin
        drop_frame();
        if (len < sfd_pkg::MIN_START_LEN || int'(len) > BUFFER_BYTES) chunk_skip = 1'b1;
      end else if (frame_need == 0 || int'(frame_fill) + int'(len) > BUFFER_BYTES) begin
        drop_frame();
        chunk_skip = 1'b1;
      end
    end else if (chunk_left == 0) begin
      return;
    end

    chunk_left = chunk_left - 1'b1;

    if (!chunk_skip) begin
      p = int'(frame_fill);
      case (p)
        1:  cmd_seen   = b;
        2:  cmp_seen   = b;
        5:  len_lo     = b;
        13: sat_seen   = b;
        15: pulse_seen = b;
        default: ;
      endcase
      // CRC covers every frame byte but the last, which carries the CRC.
      if (frame_need == 0 || p + 1 < int'(frame_need)) begin
        crc_run = crc8_next(crc_run, b);
      end else if (p + 1 == int'(frame_need)) begin
        crc_hold = crc_run;
        crc_rx   = b;
      end
      if (p == 6) begin
        w = int'({b, len_lo}) + int'(sfd_pkg::FRAME_OVERHEAD);
        if (w > BUFFER_BYTES) begin
          drop_frame();
          chunk_skip = 1'b1;
          return;
        end
        frame_need = 9'(w);
      end
      frame_fill = 10'(p + 1);
    end

    // The frame is reported at the end of the chunk that completes it.
    if (chunk_left == 0 && !chunk_skip && frame_need != 0 &&
        int'(frame_fill) >= int'(frame_need)) begin
      r = '0;
      if (cmp_seen != ~cmd_seen) r.status = sfd_pkg::STATUS_BAD_CMP;
      else if (crc_hold != crc_rx) r.status = sfd_pkg::STATUS_BAD_CRC;
      else r.status = sfd_pkg::STATUS_GOOD;
      plen = int'(frame_need) - int'(sfd_pkg::FRAME_OVERHEAD);
      r.command        = cmd_seen;
      r.payload_length = plen[7:0];
      r.has_reading    = (r.status == sfd_pkg::STATUS_GOOD && cmd_seen == sfd_pkg::LIVE_CMD &&
                          plen >= int'(sfd_pkg::MIN_READING_PAYLOAD));
      r.spo2_code      = sfd_pkg::SFLOAT_NAN;
      r.pulse_code     = sfd_pkg::SFLOAT_NAN;
      if (r.has_reading) begin
        r.spo2_value  = sat_seen;
        r.pulse_value = pulse_seen;
        if (sat_seen != 8'd0 && sat_seen <= sfd_pkg::MAX_SPO2 && pulse_seen != 8'd0 &&
            pulse_seen != sfd_pkg::PULSE_BAD && pulse_seen < sfd_pkg::PULSE_LIMIT) begin
          r.spo2_code  = {8'h00, sat_seen};
          r.pulse_code = {8'h00, pulse_seen};
        end else begin
          r.reading_invalid = 1'b1;
        end
      end
      frames_due.push_back(r);
      drop_frame();
    end
  endtask

  // Results are checked before the same edge's input byte is predicted.
  always @(posedge clk) begin
    sfd_pkg::result_t want;
    if (rst) begin
      drop_frame();
      chunk_left = '0;
      chunk_skip = 1'b0;
      len_lo     = '0;
      cmd_seen   = '0;
      cmp_seen   = '0;
      crc_hold   = '0;
      crc_rx     = '0;
      sat_seen   = '0;
      pulse_seen = '0;
      frames_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result transaction with none expected", 16'(command), 16'h0);
        end else begin
          want = frames_due.pop_front();
          compare_field("status", 16'(status), 16'(want.status));
          compare_field("command", 16'(command), 16'(want.command));
          compare_field("payload_length", 16'(payload_length), 16'(want.payload_length));
          compare_field("has_reading", 16'(has_reading), 16'(want.has_reading));
          compare_field("spo2_value", 16'(spo2_value), 16'(want.spo2_value));
          compare_field("pulse_value", 16'(pulse_value), 16'(want.pulse_value));
          compare_field("spo2_code", spo2_code, want.spo2_code);
          compare_field("pulse_code", pulse_code, want.pulse_code);
          compare_field("reading_invalid", 16'(reading_invalid), 16'(want.reading_invalid));
        end
      end
      if (in_valid && in_ready) feed_byte(data_byte, chunk_start, chunk_len);
    end
    pending = frames_due.size();
  end

endmodule

// ===== test/sensor_frame_deframer_tb.sv =====
// Testbench top for the sensor frame deframer: drives directed and random
// notification chunks, stalls the result side and gives the final verdict.
// Depends on src/sfd_pkg.sv, src/sensor_frame_deframer.sv and test/sfd_frame_checker.sv.
`timescale 1ns / 100ps

module sensor_frame_deframer_tb;

  localparam int BUFFER_BYTES = 256;
  localparam int ITEMS_TARGET = 1300;
  localparam int QUIET_FROM   = 1120;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        chunk_start = 1'b0;
  logic [9:0]  chunk_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [7:0]  payload_length;
  logic        has_reading;
  logic [7:0]  spo2_value;
  logic [7:0]  pulse_value;
  logic [15:0] spo2_code;
  logic [15:0] pulse_code;
  logic        reading_invalid;

  int         fail_count;
  int         pending;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  int         rx_hold = 0;
  bit         gaps_on = 1'b1;
  logic [7:0] frame_buf[$];

  always #5 clk = ~clk;

  sensor_frame_deframer #(.BUFFER_BYTES(BUFFER_BYTES)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .chunk_start(chunk_start), .chunk_len(chunk_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .command(command), .payload_length(payload_length),
    .has_reading(has_reading), .spo2_value(spo2_value), .pulse_value(pulse_value),
    .spo2_code(spo2_code), .pulse_code(pulse_code), .reading_invalid(reading_invalid)
  );

  sfd_frame_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .chunk_start(chunk_start), .chunk_len(chunk_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .command(command), .payload_length(payload_length),
    .has_reading(has_reading), .spo2_value(spo2_value), .pulse_value(pulse_value),
    .spo2_code(spo2_code), .pulse_code(pulse_code), .reading_invalid(reading_invalid),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side backpressure: random stall bursts.
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One input transaction, entered and left at a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic st, input logic [9:0] len);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    chunk_start <= st;
    chunk_len   <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends count bytes of the frame buffer as one chunk declaring the given length.
  task automatic send_chunk(input int from, input int count, input int declared);
    for (int i = 0; i < count; i++) push_byte(frame_buf[from + i], i == 0, declared[9:0]);
  endtask

  // Builds a frame: marker, command, complement, two spare bytes, length, payload, CRC.
  task automatic build_frame(input logic [7:0] cmd, input int plen, input bit bad_cmp,
                             input bit bad_crc, input logic [7:0] sat, input logic [7:0] pul);
    logic [7:0] crc;
    logic [7:0] cmp;
    int         body;
    cmp = ~cmd;
    if (bad_cmp) cmp = cmp ^ (8'h01 << $urandom_range(0, 7));
    // A frame declared too long is dropped at the length field; a few bytes suffice.
    body = (plen <= BUFFER_BYTES - 8) ? plen : int'($urandom_range(0, 4));
    frame_buf.delete();
    frame_buf.push_back(sfd_pkg::START_MARK);
    frame_buf.push_back(cmd);
    frame_buf.push_back(cmp);
    frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(plen[7:0]);
    frame_buf.push_back(plen[15:8]);
    repeat (body) frame_buf.push_back(8'($urandom_range(0, 255)));
    if (body >= 9) begin
      frame_buf[13] = sat;
      frame_buf[15] = pul;
    end
    crc = 8'h00;
    foreach (frame_buf[k]) crc = sfd_pkg::crc8_step(crc, frame_buf[k]);
    if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    frame_buf.push_back(crc);
  endtask

  // Sends the whole buffer split into a start chunk of at least 7 bytes and followers.
  task automatic send_split();
    int pos;
    int cnt;
    int total;
    total = frame_buf.size();
    pos = 0;
    while (pos < total) begin
      if (pos == 0) cnt = ($urandom_range(0, 1) != 0) ? total : int'($urandom_range(7, total));
      else cnt = int'($urandom_range(1, total - pos));
      send_chunk(pos, cnt, cnt);
      pos += cnt;
    end
  endtask

  // A well-formed frame with random content, sometimes corrupted or padded.
  task automatic random_frame();
    int         sel;
    int         plen;
    logic [7:0] cmd;
    logic [7:0] sat;
    logic [7:0] pul;
    if ($urandom_range(0, 1) != 0) cmd = sfd_pkg::LIVE_CMD;
    else cmd = 8'($urandom_range(0, 255));
    sel = int'($urandom_range(0, 99));
    if (sel < 72) plen = int'($urandom_range(0, 20));
    else if (sel < 94) plen = int'($urandom_range(21, 60));
    else if (sel < 97) plen = int'($urandom_range(200, BUFFER_BYTES - 8));
    else plen = int'($urandom_range(BUFFER_BYTES - 7, 65535));
    if ($urandom_range(0, 4) != 0) sat = 8'($urandom_range(1, 100));
    else sat = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) pul = 8'($urandom_range(1, 249));
    else pul = 8'($urandom_range(0, 255));
    build_frame(cmd, plen, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0, sat, pul);
    // Occasional trailing bytes past the frame end.
    if ($urandom_range(0, 9) == 0 && frame_buf.size() + 4 <= BUFFER_BYTES)
      repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_split();
  endtask

  // Broken sequences and framing noise.
  task automatic send_noise();
    int         n;
    int         first;
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: begin  // orphan chunk
        n = int'($urandom_range(1, 6));
        b = 8'($urandom_range(0, 255));
        if (b == sfd_pkg::START_MARK) b = 8'h00;
        push_byte(b, 1'b1, 10'(n));
        repeat (n - 1) push_byte(8'($urandom_range(0, 255)), 1'b0, 10'(n));
      end
      1: begin  // stray bytes
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0,
                                                10'($urandom_range(0, 1023)));
      end
      2: begin  // short start chunk
        n = int'($urandom_range(1, 6));
        push_byte(sfd_pkg::START_MARK, 1'b1, 10'(n));
        repeat (n - 1) push_byte(8'($urandom_range(0, 255)), 1'b0, 10'(n));
      end
      3: begin  // empty chunk
        push_byte(8'($urandom_range(0, 255)), 1'b1, 10'd0);
      end
      4: begin  // frame cut short by the next chunk start
        build_frame(8'($urandom_range(0, 255)), int'($urandom_range(0, 20)), 1'b0, 1'b0,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        n = frame_buf.size();
        send_chunk(0, int'($urandom_range(1, n - 1)), n + int'($urandom_range(0, 3)));
      end
      5: begin  // continuation that overflows the buffer
        build_frame(8'($urandom_range(0, 255)), int'($urandom_range(60, BUFFER_BYTES - 8)),
                    1'b0, 1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        first = int'($urandom_range(7, 20));
        send_chunk(0, first, first);
        send_chunk(first, int'($urandom_range(1, 3)),
                   int'($urandom_range(BUFFER_BYTES - first + 1, 512)));
      end
      6: begin  // oversize start chunk
        push_byte(sfd_pkg::START_MARK, 1'b1, 10'($urandom_range(BUFFER_BYTES + 1, 1023)));
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0, 10'd0);
      end
      default: begin  // random garbage with random chunk marks
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    10'($urandom_range(0, 1023)));
      end
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Framing noise: empty chunk, stray byte, orphan chunk, short start.
    push_byte(sfd_pkg::START_MARK, 1'b1, 10'd0);
    push_byte(8'h3C, 1'b0, 10'd1);
    push_byte(8'h5A, 1'b1, 10'd2);
    push_byte(8'hFF, 1'b0, 10'd2);
    push_byte(sfd_pkg::START_MARK, 1'b1, 10'd6);
    repeat (5) push_byte(8'h00, 1'b0, 10'd6);

    // Smallest frames, whole and split at the minimum start chunk.
    build_frame(8'h00, 0, 1'b0, 1'b0, 8'h00, 8'h00);
    send_chunk(0, 8, 8);
    build_frame(8'hFF, 0, 1'b0, 1'b0, 8'h00, 8'h00);
    send_chunk(0, 7, 7);
    send_chunk(7, 1, 1);

    // Bad complement and bad CRC.
    build_frame(8'h11, 3, 1'b1, 1'b0, 8'h00, 8'h00);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(8'h22, 3, 1'b0, 1'b1, 8'h00, 8'h00);
    send_chunk(0, frame_buf.size(), frame_buf.size());

    // Live-sample readings at and beyond the validity limits.
    build_frame(sfd_pkg::LIVE_CMD, 9, 1'b0, 1'b0, 8'd1, 8'd1);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 9, 1'b0, 1'b0, 8'd100, 8'd249);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 12, 1'b0, 1'b0, 8'd0, 8'd60);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 9, 1'b0, 1'b0, 8'd101, 8'd60);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 9, 1'b0, 1'b0, 8'd98, 8'd250);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 9, 1'b0, 1'b0, 8'd98, 8'd255);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 9, 1'b0, 1'b0, 8'd98, 8'd0);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 8, 1'b0, 1'b0, 8'd98, 8'd70);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(sfd_pkg::LIVE_CMD, 10, 1'b0, 1'b1, 8'd98, 8'd70);
    send_chunk(0, frame_buf.size(), frame_buf.size());

    // Declared frame longer than the buffer, by one byte and by the high length byte.
    build_frame(8'h30, BUFFER_BYTES - 7, 1'b0, 1'b0, 8'h00, 8'h00);
    send_chunk(0, frame_buf.size(), frame_buf.size());
    build_frame(8'h31, 256, 1'b0, 1'b0, 8'h00, 8'h00);
    send_chunk(0, frame_buf.size(), frame_buf.size());

    // Oversize start chunks, each cut short by the next start.
    push_byte(sfd_pkg::START_MARK, 1'b1, 10'(BUFFER_BYTES + 1));
    push_byte(8'h01, 1'b0, 10'd0);
    push_byte(sfd_pkg::START_MARK, 1'b1, 10'd512);
    push_byte(8'h02, 1'b0, 10'd0);

    // Continuation chunk that would overflow the buffer.
    build_frame(8'h40, BUFFER_BYTES - 8, 1'b0, 1'b0, 8'h00, 8'h00);
    send_chunk(0, 7, 7);
    send_chunk(7, 3, BUFFER_BYTES - 6);

    // Excess bytes after the frame end within the completing chunk.
    build_frame(8'h41, 2, 1'b0, 1'b0, 8'h00, 8'h00);
    repeat (3) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_chunk(0, frame_buf.size(), frame_buf.size());

    // Truncated chunk, then the largest frame in one chunk.
    build_frame(8'h42, 10, 1'b0, 1'b0, 8'h00, 8'h00);
    send_chunk(0, 5, 18);
    build_frame(sfd_pkg::LIVE_CMD, BUFFER_BYTES - 8, 1'b0, 1'b0, 8'd95, 8'd72);
    send_chunk(0, frame_buf.size(), frame_buf.size());

    // Random part: mostly well-formed frames, the rest noise; quiet at the end.
    while (items_sent < ITEMS_TARGET) begin
      if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
      else if ($urandom_range(0, 19) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 75) random_frame();
      else send_noise();
    end
    in_valid <= 1'b0;

    // Drain, then give any late result time to show up.
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
